>>> sv/dtc_pkg.sv
// Package for the decreasing tuple counter: widths, constants, types and helpers.
package dtc_pkg;

	// Field and storage widths
	localparam int RANK_W  = 21;
	localparam int ADDR_W  = 20;
	localparam int POS_W   = RANK_W + 1;
	localparam int NODE_W  = 64;
	localparam int OUT_W   = 60;
	localparam int ACC_W   = OUT_W + 1;

	// Number of rank positions held in each tree
	localparam logic [RANK_W-1:0] MAX_LEN = RANK_W'(1) << ADDR_W;
	localparam logic [RANK_W-1:0] LEN_RESET = MAX_LEN;

	// Output limits
	localparam logic [OUT_W-1:0] OUT_MAX   = '1;
	localparam logic [OUT_W-1:0] TOTAL_MOD = 60'd1000000000000000000;

	// Walk sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_QUERY,
		ST_UPDATE,
		ST_ADD,
		ST_RED1,
		ST_RED2
	} dtc_state_t;

	// Item request from the top level to the sequencer
	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [RANK_W-1:0] limit;
	} dtc_req_t;

	// Sequencer status towards the top level
	typedef struct packed {
		logic req_ready;
		logic clearing;
	} dtc_stat_t;

	// Finished result
	typedef struct packed {
		logic [OUT_W-1:0] count;
		logic [OUT_W-1:0] total;
	} dtc_res_t;

	// Saturating add of two tree nodes
	function automatic logic [NODE_W-1:0] sat_add(input logic [NODE_W-1:0] a,
		input logic [NODE_W-1:0] b);
		logic [NODE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[NODE_W] ? '1 : s[NODE_W-1:0];
	endfunction

	// Lowest set bit of a tree position
	function automatic logic [POS_W-1:0] low_bit(input logic [POS_W-1:0] x);
		return x & (~x + POS_W'(1));
	endfunction

endpackage

>>> sv/dtc_cfg_if.sv
// Configuration write channel carrying the sequence length.
interface dtc_cfg_if import dtc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [RANK_W-1:0] sequence_length;

	modport source (output valid, output sequence_length, input ready);
	modport sink   (input valid, input sequence_length, output ready);
endinterface

>>> sv/dtc_rank_if.sv
// Input channel carrying one rank per beat.
interface dtc_rank_if import dtc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [RANK_W-1:0] rank;

	modport source (output valid, output rank, input ready);
	modport sink   (input valid, input rank, output ready);
endinterface

>>> sv/dtc_result_if.sv
// Result channel carrying the tuple count and the running total.
interface dtc_result_if import dtc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] tuples_ending_here;
	logic [OUT_W-1:0] running_total;

	modport source (output valid, output tuples_ending_here, output running_total,
		input ready);
	modport sink   (input valid, input tuples_ending_here, input running_total,
		output ready);
endinterface

>>> sv/dtc_tree_ram.sv
// One Fenwick tree level: single write port, single read port, registered read.
module dtc_tree_ram import dtc_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [NODE_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [NODE_W-1:0] rdata
);

	logic [NODE_W-1:0] mem [2**ADDR_W];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/dtc_walk_ctrl.sv
// Fenwick walk sequencer: clearing pass, prefix query, node update, modular total.
module dtc_walk_ctrl import dtc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  dtc_req_t  req,
	output dtc_stat_t stat,
	output logic      res_valid,
	input  logic      res_ready,
	output dtc_res_t  res
);

	dtc_state_t state_q, state_d;

	logic [ADDR_W-1:0] clr_q;
	logic [RANK_W-1:0] rank_q;
	logic [RANK_W-1:0] limit_q;
	logic [POS_W-1:0]  pos_q;
	logic [NODE_W-1:0] sum0_q;
	logic [NODE_W-1:0] sum1_q;
	logic [OUT_W-1:0]  count_q;
	logic [ACC_W-1:0]  acc_q;
	logic [OUT_W-1:0]  total_q;
	logic              rd_pend_s1;
	logic [ADDR_W-1:0] wr_addr_s1;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [NODE_W-1:0] wdata0;
	logic [NODE_W-1:0] wdata1;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [NODE_W-1:0] rdata0;
	logic [NODE_W-1:0] rdata1;

	logic [POS_W-1:0]  pos_dec;
	logic              upd_in_range;
	logic [RANK_W-1:0] rank_m1;
	logic [RANK_W-1:0] qpos;
	logic [OUT_W-1:0]  count_sat;
	logic [ACC_W-1:0]  acc_red;

	// Walk arithmetic
	assign pos_dec      = pos_q - POS_W'(1);
	assign upd_in_range = (pos_q != '0) && (pos_q <= {1'b0, limit_q});
	assign rank_m1      = req.rank - RANK_W'(1);
	assign qpos         = (rank_m1 < req.limit) ? rank_m1 : req.limit;
	assign count_sat    = (sum1_q > {{(NODE_W-OUT_W){1'b0}}, OUT_MAX}) ? OUT_MAX
		: sum1_q[OUT_W-1:0];
	assign acc_red      = (acc_q >= {1'b0, TOTAL_MOD}) ? acc_q - {1'b0, TOTAL_MOD} : acc_q;

	// Memory port steering
	assign mem_re    = ((state_q == ST_QUERY) && (pos_q != '0))
		|| ((state_q == ST_UPDATE) && upd_in_range);
	assign mem_raddr = pos_dec[ADDR_W-1:0];
	assign mem_we    = (state_q == ST_CLEAR) || ((state_q == ST_UPDATE) && rd_pend_s1);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : wr_addr_s1;
	assign wdata0    = (state_q == ST_CLEAR) ? '0 : sat_add(rdata0, NODE_W'(1));
	assign wdata1    = (state_q == ST_CLEAR) ? '0 : sat_add(rdata1, sum0_q);

	// Level 1 and level 2 trees
	dtc_tree_ram u_tree0 (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (wdata0),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata0)
	);

	dtc_tree_ram u_tree1 (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (wdata1),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata1)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and status
	always_comb begin
		state_d        = state_q;
		stat.req_ready = 1'b0;
		stat.clearing  = 1'b0;
		res_valid      = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				stat.clearing = 1'b1;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				stat.req_ready = 1'b1;
				if (req_valid) begin
					state_d = (req.rank == '0) ? ST_ADD : ST_QUERY;
				end
			end
			ST_QUERY: begin
				if (pos_q == '0) begin
					state_d = (rank_q <= limit_q) ? ST_UPDATE : ST_ADD;
				end
			end
			ST_UPDATE: begin
				if (!upd_in_range) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD:  state_d = ST_RED1;
			ST_RED1: state_d = ST_RED2;
			ST_RED2: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			rd_pend_s1 <= 1'b0;
			total_q    <= '0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			rd_pend_s1 <= mem_re;
			if ((state_q == ST_RED2) && res_ready) begin
				total_q <= acc_red[OUT_W-1:0];
			end
		end
	end

	// Walk datapath
	always_ff @(posedge clk) begin
		if (mem_re) begin
			wr_addr_s1 <= mem_raddr;
		end
		case (state_q)
			ST_IDLE: begin
				rank_q  <= req.rank;
				limit_q <= req.limit;
				pos_q   <= {1'b0, qpos};
				sum0_q  <= '0;
				sum1_q  <= '0;
			end
			ST_QUERY: begin
				if (rd_pend_s1) begin
					sum0_q <= sat_add(sum0_q, rdata0);
					sum1_q <= sat_add(sum1_q, rdata1);
				end
				if (pos_q != '0) begin
					pos_q <= pos_q - low_bit(pos_q);
				end else begin
					pos_q <= {1'b0, rank_q};
				end
			end
			ST_UPDATE: begin
				if (upd_in_range) begin
					pos_q <= pos_q + low_bit(pos_q);
				end
			end
			ST_ADD: begin
				count_q <= count_sat;
				acc_q   <= {1'b0, total_q} + {1'b0, count_sat};
			end
			ST_RED1: begin
				acc_q <= acc_red;
			end
			default: begin
			end
		endcase
	end

	// Result towards the output register
	assign res.count = count_q;
	assign res.total = acc_red[OUT_W-1:0];

endmodule

>>> sv/decreasing_tuple_counter_unit.sv
// Top level of the decreasing tuple counter: handshakes, length register, output register.
// Counts strictly decreasing triples ending at each incoming rank using two Fenwick trees of
// 2^20 64-bit nodes held in single-port-read RAMs. After reset a clearing pass zeroes both trees,
// one address per cycle; no item is accepted until it ends, while configuration writes are
// taken at any time. An item whose rank is within the bound then runs a query walk down from
// min(rank-1, limit) and an update walk over the tree nodes from rank up to the limit; a rank
// beyond the bound skips the update walk, and rank zero skips both walks. An item also waits
// while the output register is full. The walks issue one read per cycle at the tree read
// port, and states ST_ADD, ST_RED1 and ST_RED2 fold the count into the running total modulo
// 10^18. One item is in flight at a time; a finished result sits in the output register while
// the next item is already accepted.
module decreasing_tuple_counter_unit import dtc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	dtc_cfg_if.sink      cfg,
	dtc_rank_if.sink     items,
	dtc_result_if.source results
);

	logic [RANK_W-1:0] seq_len_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_count_q;
	logic [OUT_W-1:0]  out_total_q;

	dtc_req_t  req;
	dtc_stat_t stat;
	dtc_res_t  res;
	logic      res_valid;
	logic      res_ready;

	// Length register, written whenever a beat arrives
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len_q <= LEN_RESET;
		end else if (cfg.valid) begin
			seq_len_q <= cfg.sequence_length;
		end
	end

	// Item request
	assign items.ready = stat.req_ready;
	assign req.rank    = items.rank;
	assign req.limit   = (seq_len_q < MAX_LEN) ? seq_len_q : MAX_LEN;

	dtc_walk_ctrl u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (items.valid),
		.req       (req),
		.stat      (stat),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register
	assign res_ready = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_count_q <= res.count;
			out_total_q <= res.total;
		end
	end

	assign results.valid              = out_valid_q;
	assign results.tuples_ending_here = out_count_q;
	assign results.running_total      = out_total_q;

	// Checks
	a_total_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.running_total < TOTAL_MOD))
		else $error("running total not reduced");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready) |=> !items.ready)
		else $error("second item taken while one is in flight");

	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res)))
		else $error("result dropped while output register full");

	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !items.ready)
		else $error("item accepted during clearing pass");

endmodule

>>> tb/dtc_triple_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard for the decreasing tuple counter: predicts each result beat from the rank beats.
module dtc_triple_scoreboard import dtc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	dtc_cfg_if    cfg,
	dtc_rank_if   items,
	dtc_result_if results,
	output int    failures,
	output int    pending,
	output int    checked,
	output int    nonzero
);

	// Which of the two kept Fenwick trees a walk touches
	typedef enum bit {
		LVL_SINGLE,
		LVL_PAIR
	} tree_level_t;

	// Sparse copies of the trees: singles per rank, decreasing pairs per rank
	logic [NODE_W-1:0] single_tree [int unsigned];
	logic [NODE_W-1:0] pair_tree   [int unsigned];
	logic [RANK_W-1:0] length_q;
	logic [NODE_W-1:0] total_q;
	dtc_res_t          expected_q [$];
	int                fail_n;
	int                check_n;
	int                nonzero_n;

	// Adds with a ceiling at the all-ones node value
	function automatic logic [NODE_W-1:0] clip_add(input logic [NODE_W-1:0] a,
		input logic [NODE_W-1:0] b);
		logic [NODE_W-1:0] s;
		s = a + b;
		return (s < a) ? '1 : s;
	endfunction

	function automatic logic [NODE_W-1:0] node_at(input tree_level_t lvl, input int unsigned pos);
		if (lvl == LVL_SINGLE) begin
			return single_tree.exists(pos) ? single_tree[pos] : '0;
		end
		return pair_tree.exists(pos) ? pair_tree[pos] : '0;
	endfunction

	// Upward walk: add amount at pos and every covering node up to the bound
	function automatic void tree_bump(input tree_level_t lvl, input int unsigned pos,
		input logic [NODE_W-1:0] amount, input int unsigned lim);
		logic [NODE_W-1:0] v;
		while (pos >= 1 && pos <= lim) begin
			v = clip_add(node_at(lvl, pos), amount);
			if (lvl == LVL_SINGLE) begin
				single_tree[pos] = v;
			end else begin
				pair_tree[pos] = v;
			end
			pos += pos & (~pos + 1);
		end
	endfunction

	// Downward walk: sum over ranks 1..pos, pos clipped to the bound
	function automatic logic [NODE_W-1:0] tree_prefix_sum(input tree_level_t lvl,
		input int unsigned pos, input int unsigned lim);
		logic [NODE_W-1:0] acc;
		acc = '0;
		if (pos > lim) begin
			pos = lim;
		end
		while (pos > 0) begin
			acc = clip_add(acc, node_at(lvl, pos));
			pos -= pos & (~pos + 1);
		end
		return acc;
	endfunction

	// Triples ending at this rank, and the running total after it
	function automatic dtc_res_t predict_triples(input logic [RANK_W-1:0] r);
		int unsigned       lim;
		int unsigned       pos;
		logic [NODE_W-1:0] pairs;
		logic [NODE_W-1:0] triples;
		dtc_res_t          res;
		lim = 32'((length_q < MAX_LEN) ? length_q : MAX_LEN);
		pos = 32'(r);
		triples = '0;
		// rank zero touches nothing and counts nothing
		if (pos != 0) begin
			tree_bump(LVL_SINGLE, pos, NODE_W'(1), lim);
			pairs = tree_prefix_sum(LVL_SINGLE, pos - 1, lim);
			tree_bump(LVL_PAIR, pos, pairs, lim);
			triples = tree_prefix_sum(LVL_PAIR, pos - 1, lim);
		end
		if (triples > NODE_W'(OUT_MAX)) begin
			triples = NODE_W'(OUT_MAX);
		end
		total_q = (total_q + triples) % NODE_W'(TOTAL_MOD);
		res.count = triples[OUT_W-1:0];
		res.total = total_q[OUT_W-1:0];
		return res;
	endfunction

	// Watch the three channels; length first, then new ranks, then result beats
	always @(posedge clk or negedge arst_n) begin
		dtc_res_t want;
		if (!arst_n) begin
			single_tree.delete();
			pair_tree.delete();
			expected_q.delete();
			length_q = LEN_RESET;
			total_q = '0;
			fail_n = 0;
			check_n = 0;
			nonzero_n = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				length_q = cfg.sequence_length;
			end
			if (items.valid && items.ready) begin
				expected_q.push_back(predict_triples(items.rank));
			end
			if (results.valid && results.ready) begin
				if (expected_q.size() == 0) begin
					$error("result beat with nothing outstanding: count %0d, total %0d",
						results.tuples_ending_here, results.running_total);
					fail_n++;
				end else begin
					want = expected_q.pop_front();
					if (results.tuples_ending_here !== want.count) begin
						$error("tuples_ending_here: expected %0d, got %0d",
							want.count, results.tuples_ending_here);
						fail_n++;
					end
					if (results.running_total !== want.total) begin
						$error("running_total: expected %0d, got %0d",
							want.total, results.running_total);
						fail_n++;
					end
					check_n++;
					if (want.count != 0) begin
						nonzero_n++;
					end
				end
			end
		end
		failures <= fail_n;
		pending  <= expected_q.size();
		checked  <= check_n;
		nonzero  <= nonzero_n;
	end

endmodule

>>> tb/decreasing_tuple_counter_unit_test.sv
`timescale 1ns / 100ps
// Top of the decreasing tuple counter testbench: clock, reset, rank and length stimulus, verdict.
module decreasing_tuple_counter_unit_test import dtc_pkg::*; ();

	localparam int LONG_HOLD    = 300;
	localparam int PHASE_ITEMS  = 56;
	localparam int DRAIN_CYCLES = 64;

	logic clk;
	logic arst_n;
	int   failures;
	int   pending;
	int   checked;
	int   nonzero;
	bit   quiet;
	int   holds_asked;
	int   holds_done;
	int   beats_sent;
	int   settings;
	logic [RANK_W-1:0] last_rank;

	dtc_cfg_if    cfg ();
	dtc_rank_if   items ();
	dtc_result_if results ();

	decreasing_tuple_counter_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.items   (items),
		.results (results)
	);

	dtc_triple_scoreboard scoreboard (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.items    (items),
		.results  (results),
		.failures (failures),
		.pending  (pending),
		.checked  (checked),
		.nonzero  (nonzero)
	);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop; covers the clearing pass after reset several times over
	initial begin
		#25_000_000;
		$display("decreasing_tuple_counter_unit_test: FAIL");
		$finish;
	end

	// Idle stretch: mostly none or short, now and then long; none in quiet phases
	function automatic int idle_len();
		int p;
		p = $urandom_range(0, 99);
		if (quiet || p < 55) begin
			return 0;
		end
		if (p < 88) begin
			return $urandom_range(1, 3);
		end
		if (p < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Mostly in-range ranks with falling runs; some zero, beyond-bound and full-width noise
	function automatic logic [RANK_W-1:0] pick_rank(input int unsigned lim);
		int p;
		p = $urandom_range(0, 99);
		if (lim == 0 || p < 3) begin
			return RANK_W'($urandom);
		end
		if (p < 6) begin
			return '0;
		end
		if (p < 10) begin
			return RANK_W'($urandom_range(lim + 1, (1 << RANK_W) - 1));
		end
		if (p < 35 && last_rank > 1 && last_rank <= lim) begin
			return last_rank - RANK_W'($urandom_range(1, (last_rank > 4) ? 3 : 1));
		end
		return RANK_W'($urandom_range(1, lim));
	endfunction

	// One length beat; valid drops in the step the beat is taken
	task automatic set_length(input logic [RANK_W-1:0] v);
		cfg.valid <= 1'b1;
		cfg.sequence_length <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		settings++;
	endtask

	// One rank beat, then maybe a gap; valid stays up when there is none
	task automatic send_rank(input logic [RANK_W-1:0] r);
		int g;
		items.valid <= 1'b1;
		items.rank <= r;
		do @(posedge clk); while (!items.ready);
		beats_sent++;
		last_rank = r;
		g = idle_len();
		if (g != 0) begin
			items.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Sender pauses until every outstanding result beat has come back
	task automatic wait_drained();
		items.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Result side: random back-pressure, plus long hold-offs on request
	initial begin
		int g;
		holds_done = 0;
		results.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			g = idle_len();
			if (holds_done != holds_asked) begin
				holds_done++;
				g = LONG_HOLD;
			end
			if (g != 0) begin
				results.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			results.ready <= 1'b1;
			do @(posedge clk); while (!results.valid);
		end
	end

	// Stimulus
	initial begin
		logic [RANK_W-1:0] lens [7];
		int unsigned       lim;
		lens = '{RANK_W'(16), RANK_W'(300), '1, RANK_W'(5), '0, MAX_LEN, RANK_W'(40)};
		arst_n <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.sequence_length <= '0;
		items.valid <= 1'b0;
		items.rank <= '0;
		quiet = 1'b0;
		holds_asked = 0;
		beats_sent = 0;
		settings = 0;
		last_rank = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Short bound: strictly falling run, then zero, beyond-bound, all-ones and repeats
		set_length(RANK_W'(8));
		for (int i = 8; i >= 1; i--) begin
			send_rank(RANK_W'(i));
		end
		send_rank('0);
		send_rank(RANK_W'(9));
		send_rank('1);
		send_rank(RANK_W'(1));
		send_rank(RANK_W'(8));
		wait_drained();

		// Smallest bound
		set_length(RANK_W'(1));
		send_rank(RANK_W'(1));
		send_rank(RANK_W'(1));
		send_rank(RANK_W'(2));
		wait_drained();

		// Full bound, top rank and deep walks; trees carry over from before
		set_length(MAX_LEN);
		send_rank(MAX_LEN);
		send_rank(MAX_LEN - 1);
		send_rank(RANK_W'(524288));
		send_rank(RANK_W'(3));
		send_rank(RANK_W'(2));
		send_rank(RANK_W'(1));
		wait_drained();

		// Random phases, one bound each; first with no idling, second with a long hold-off
		foreach (lens[k]) begin
			quiet = (k == 0);
			if (k == 1) begin
				holds_asked++;
			end
			set_length(lens[k]);
			lim = 32'((lens[k] < MAX_LEN) ? lens[k] : MAX_LEN);
			repeat (PHASE_ITEMS) send_rank(pick_rank(lim));
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d bound settings (0 up to all ones) over %0d rank beats.",
			settings, beats_sent);
		$display("Checked %0d result beats, %0d of them with decreasing triples.",
			checked, nonzero);
		if (failures == 0 && pending == 0) begin
			$display("decreasing_tuple_counter_unit_test: PASS");
		end else begin
			$display("decreasing_tuple_counter_unit_test: FAIL");
		end
		$finish;
	end

endmodule

>>> decreasing_tuple_counter_unit.f
sv/dtc_pkg.sv
sv/dtc_cfg_if.sv
sv/dtc_rank_if.sv
sv/dtc_result_if.sv
sv/dtc_tree_ram.sv
sv/dtc_walk_ctrl.sv
sv/decreasing_tuple_counter_unit.sv
tb/dtc_triple_scoreboard.sv
tb/decreasing_tuple_counter_unit_test.sv
